### rtl/cau_pkg.sv
package cau_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_W = 8;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;

	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = 2 * DATA_W + 2;
	localparam int MAG_W  = SUM_W - 1;
	localparam int DEN_W  = 2 * DATA_W;
	localparam int QW     = DATA_W + 1;
	localparam int NUM_W  = MAG_W + FRAC_W;
	localparam int DSH_W  = DEN_W + QW;
	localparam int WW     = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;

	localparam int IN_W   = ((FUNC_W + 4 * DATA_W + 7) / 8) * 8;
	localparam int OUT_W  = ((2 * DATA_W + STAT_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_NEG = 3'd2,
		FN_MUL = 3'd3,
		FN_DIV = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} stat_t;

	localparam logic signed [SUM_W-1:0] POS_L = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] NEG_L = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic              sat;
		logic [DATA_W-1:0] val;
	} clamp_t;

	// item travelling down the divider chain
	typedef struct packed {
		logic              valid;
		logic              is_div;
		logic              ovf_re;
		logic              ovf_im;
		logic              neg_re;
		logic              neg_im;
		logic [WW-1:0]     rem_re;
		logic [WW-1:0]     rem_im;
		logic [WW-1:0]     dsh;
		logic [QW-1:0]     q_re;
		logic [QW-1:0]     q_im;
		logic [DATA_W-1:0] res_re;
		logic [DATA_W-1:0] res_im;
		stat_t             status;
	} cell_t;

	function automatic clamp_t clamp_fn(input logic signed [SUM_W-1:0] v);
		clamp_t r;
		r.sat = 1'b0;
		r.val = v[DATA_W-1:0];
		if (v > POS_L) begin
			r.sat = 1'b1;
			r.val = POS_L[DATA_W-1:0];
		end else if (v < NEG_L) begin
			r.sat = 1'b1;
			r.val = NEG_L[DATA_W-1:0];
		end
		return r;
	endfunction

	// saturate an unsigned quotient with its sign
	function automatic clamp_t qclamp_fn(input logic neg, input logic ovf,
			input logic [QW-1:0] q);
		clamp_t r;
		logic   big;
		if (neg) begin
			big   = ovf | q[QW-1] | (q[QW-2] & (|q[QW-3:0]));
			r.sat = big;
			r.val = big ? NEG_L[DATA_W-1:0] : DATA_W'(~q + 1'b1);
		end else begin
			big   = ovf | q[QW-1] | q[QW-2];
			r.sat = big;
			r.val = big ? POS_L[DATA_W-1:0] : q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/cau_front.sv
module cau_front import cau_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] a_re,
	input  logic signed [DATA_W-1:0] a_im,
	input  logic signed [DATA_W-1:0] b_re,
	input  logic signed [DATA_W-1:0] b_im,
	output cell_t                    out
);

	logic                     v_s1;
	logic [FUNC_W-1:0]        func_s1;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1, sq0_s1, sq1_s1;
	clamp_t                   sr_s1, si_s1;

	logic signed [SUM_W-1:0] ear, eai, ebr, ebi, lin_re, lin_im;

	always_comb begin
		ear = SUM_W'(a_re);
		eai = SUM_W'(a_im);
		ebr = SUM_W'(b_re);
		ebi = SUM_W'(b_im);
		lin_re = '0;
		lin_im = '0;
		case (func)
			FN_ADD: begin
				lin_re = ear + ebr;
				lin_im = eai + ebi;
			end
			FN_SUB: begin
				lin_re = ear - ebr;
				lin_im = eai - ebi;
			end
			FN_NEG: begin
				lin_re = -ear;
				lin_im = -eai;
			end
			default: begin
				lin_re = '0;
				lin_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			p0_s1   <= a_re * b_re;
			p1_s1   <= a_im * b_im;
			p2_s1   <= a_re * b_im;
			p3_s1   <= a_im * b_re;
			sq0_s1  <= b_re * b_re;
			sq1_s1  <= b_im * b_im;
			sr_s1   <= clamp_fn(lin_re);
			si_s1   <= clamp_fn(lin_im);
		end
	end

	logic signed [SUM_W-1:0] mul_re, mul_im, div_re, div_im;
	logic [MAG_W-1:0]        mag_re, mag_im;
	logic [WW-1:0]           n_re, n_im, den_w, lim;
	logic [DEN_W-1:0]        den;
	clamp_t                  cm_re, cm_im;
	cell_t                   nx;

	always_comb begin
		mul_re = SUM_W'(p0_s1) - SUM_W'(p1_s1);
		mul_im = SUM_W'(p2_s1) + SUM_W'(p3_s1);
		div_re = SUM_W'(p0_s1) + SUM_W'(p1_s1);
		div_im = SUM_W'(p3_s1) - SUM_W'(p2_s1);
		cm_re  = clamp_fn(mul_re >>> FRAC_W);
		cm_im  = clamp_fn(mul_im >>> FRAC_W);
		mag_re = div_re[SUM_W-1] ? MAG_W'(-div_re) : MAG_W'(div_re);
		mag_im = div_im[SUM_W-1] ? MAG_W'(-div_im) : MAG_W'(div_im);
		n_re   = WW'({mag_re, {FRAC_W{1'b0}}});
		n_im   = WW'({mag_im, {FRAC_W{1'b0}}});
		den    = sq0_s1[DEN_W-1:0] + sq1_s1[DEN_W-1:0];
		den_w  = WW'(den);
		lim    = den_w << QW;

		nx        = '0;
		nx.valid  = v_s1;
		nx.status = ST_OK;
		nx.dsh    = den_w << (QW - 1);
		nx.rem_re = n_re;
		nx.rem_im = n_im;
		nx.neg_re = div_re[SUM_W-1];
		nx.neg_im = div_im[SUM_W-1];
		nx.ovf_re = n_re >= lim;
		nx.ovf_im = n_im >= lim;
		case (func_s1)
			FN_ADD, FN_SUB, FN_NEG: begin
				nx.res_re = sr_s1.val;
				nx.res_im = si_s1.val;
				nx.status = (sr_s1.sat | si_s1.sat) ? ST_SAT : ST_OK;
			end
			FN_MUL: begin
				nx.res_re = cm_re.val;
				nx.res_im = cm_im.val;
				nx.status = (cm_re.sat | cm_im.sat) ? ST_SAT : ST_OK;
			end
			FN_DIV: begin
				if (den == '0) begin
					nx.status = ST_DZ;
				end else begin
					nx.is_div = 1'b1;
				end
			end
			default: begin
				nx.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out <= '0;
		end else if (en) begin
			out <= nx;
		end
	end

endmodule

### rtl/cau_div_cell.sv
module cau_div_cell import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t din,
	output cell_t dout
);

	logic  ge_re, ge_im;
	cell_t nx;

	// one restoring step per cell for both parts; divisor walks right by one
	always_comb begin
		ge_re     = din.rem_re >= din.dsh;
		ge_im     = din.rem_im >= din.dsh;
		nx        = din;
		nx.rem_re = ge_re ? din.rem_re - din.dsh : din.rem_re;
		nx.rem_im = ge_im ? din.rem_im - din.dsh : din.rem_im;
		nx.q_re   = {din.q_re[QW-2:0], ge_re};
		nx.q_im   = {din.q_im[QW-2:0], ge_im};
		nx.dsh    = din.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nx;
		end
	end

endmodule

### rtl/complex_arith_unit.sv
// channel   | group                | fields (lsb first)
// ----------+----------------------+--------------------------------------------
// operands  | s_tvalid/tready/data | func[2:0] a_re[18:3] a_im[34:19] b_re[50:35]
//           |                      | b_im[66:51], zero to bit 71
// result    | m_tvalid/tready/data | res_re[15:0] res_im[31:16] status[33:32]
//
// One item per cycle while not stalled. Stages: multipliers, combine, 17 divider
// cells (one quotient bit each), output register; every op goes the same path.
// The whole pipe advances while the output register is empty or being taken.
// Reset clears the valid flags and the divider chain; no warm-up.
module complex_arith_unit import cau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // func, a_re, a_im, b_re, b_im
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // res_re, res_im, status
);

	logic  en;
	cell_t chain [QW+1];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.func     (s_tdata[FUNC_W-1:0]),
		.a_re     (s_tdata[FUNC_W +: DATA_W]),
		.a_im     (s_tdata[FUNC_W+DATA_W +: DATA_W]),
		.b_re     (s_tdata[FUNC_W+2*DATA_W +: DATA_W]),
		.b_im     (s_tdata[FUNC_W+3*DATA_W +: DATA_W]),
		.out      (chain[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_cell
		cau_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	cell_t             last;
	clamp_t            qr, qi;
	logic [DATA_W-1:0] fin_re, fin_im;
	stat_t             fin_st;
	logic              valid_q;
	logic [DATA_W-1:0] res_re_q, res_im_q;
	stat_t             status_q;

	always_comb begin
		last   = chain[QW];
		qr     = qclamp_fn(last.neg_re, last.ovf_re, last.q_re);
		qi     = qclamp_fn(last.neg_im, last.ovf_im, last.q_im);
		fin_re = last.res_re;
		fin_im = last.res_im;
		fin_st = last.status;
		if (last.is_div) begin
			fin_re = qr.val;
			fin_im = qi.val;
			fin_st = (qr.sat | qi.sat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= fin_re;
			res_im_q <= fin_im;
			status_q <= fin_st;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'({status_q, res_im_q, res_re_q});

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_DZ) |-> (res_re_q == '0 && res_im_q == '0))
		else $error("divide by zero item with non-zero data");

	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_q == ST_OK || status_q == ST_SAT || status_q == ST_DZ))
		else $error("undefined status code");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> ($stable(last.valid) && $stable(res_re_q)))
		else $error("pipe moved while stalled");

	a_div_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(last.valid && last.is_div) |-> last.status == ST_OK)
		else $error("divide item carries a status before the quotient is done");

endmodule

### bench/complex_arith_unit_tb.sv
`timescale 1ns / 100ps

module complex_arith_unit_tb;
	import cau_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int DRAIN_CYC  = 40;

	typedef struct {
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		stat_t             st;
	} cplx_res_t;

	class cau_scoreboard;
		cplx_res_t pending[$];
		int        mismatches;
		int        checked;
		int        n_sat;
		int        n_dz;
		int        n_op[8];

		function void clamp16(input longint v, output logic [DATA_W-1:0] o, inout bit s);
			if (v > 32767) begin
				o = 16'h7fff;
				s = 1;
			end else if (v < -32768) begin
				o = 16'h8000;
				s = 1;
			end else begin
				o = v[DATA_W-1:0];
			end
		endfunction

		// magnitude scaled and divided, sign put back: truncates toward zero
		function longint quot_part(longint num, longint den);
			longint m;
			longint q;
			m = (num < 0) ? -num : num;
			q = (m <<< FRAC_W) / den;
			return (num < 0) ? -q : q;
		endfunction

		function void note_operands(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] ar,
				logic signed [DATA_W-1:0] ai, logic signed [DATA_W-1:0] br,
				logic signed [DATA_W-1:0] bi);
			cplx_res_t e;
			longint    xr, xi, den;
			bit        s;
			s    = 0;
			e.re = '0;
			e.im = '0;
			e.st = ST_OK;
			n_op[f]++;
			case (func_t'(f))
				FN_ADD: begin
					clamp16(longint'(ar) + longint'(br), e.re, s);
					clamp16(longint'(ai) + longint'(bi), e.im, s);
				end
				FN_SUB: begin
					clamp16(longint'(ar) - longint'(br), e.re, s);
					clamp16(longint'(ai) - longint'(bi), e.im, s);
				end
				FN_NEG: begin
					clamp16(-longint'(ar), e.re, s);
					clamp16(-longint'(ai), e.im, s);
				end
				FN_MUL: begin
					xr = longint'(ar) * br - longint'(ai) * bi;
					xi = longint'(ar) * bi + longint'(ai) * br;
					clamp16(xr >>> FRAC_W, e.re, s);
					clamp16(xi >>> FRAC_W, e.im, s);
				end
				FN_DIV: begin
					den = longint'(br) * br + longint'(bi) * bi;
					if (den == 0) begin
						e.st = ST_DZ;
					end else begin
						xr = longint'(ar) * br + longint'(ai) * bi;
						xi = longint'(ai) * br - longint'(ar) * bi;
						clamp16(quot_part(xr, den), e.re, s);
						clamp16(quot_part(xi, den), e.im, s);
					end
				end
				default: ;
			endcase
			if (e.st == ST_OK && s)
				e.st = ST_SAT;
			if (e.st == ST_SAT)
				n_sat++;
			if (e.st == ST_DZ)
				n_dz++;
			pending.push_back(e);
		endfunction

		function void check_result(logic [DATA_W-1:0] re, logic [DATA_W-1:0] im,
				logic [STAT_W-1:0] st);
			cplx_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: re=%h im=%h st=%0d", re, im, st);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (re !== e.re || im !== e.im || st !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: exp re=%h im=%h st=%s, got re=%h im=%h st=%0d",
						checked, e.re, e.im, e.st.name(), re, im, st);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;  // func, a_re, a_im, b_re, b_im
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;  // res_re, res_im, status

	cau_scoreboard sb;
	int            src_idle_pct;
	int            snk_idle_pct;
	int            wdog;

	complex_arith_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// accepted items on both sides, sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_operands(s_tdata[2:0], s_tdata[18:3], s_tdata[34:19],
					s_tdata[50:35], s_tdata[66:51]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[15:0], m_tdata[31:16], m_tdata[33:32]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WDOG_LIMIT);
				$display("** complex_arith_unit: FAILED **");
				$finish;
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

	task automatic send(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] ar, logic [DATA_W-1:0] ai,
			logic [DATA_W-1:0] br, logic [DATA_W-1:0] bi);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, bi, br, ai, ar, f};
		do @(posedge clk); while (!s_tready);
	endtask

	// wait for a clock edge first so the last accepted item is already noted
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_val();
		case ($urandom_range(0, 3))
			0:       return DATA_W'($urandom);
			1:       return DATA_W'($urandom_range(0, 4095)) - 16'd2048;
			2: begin
				case ($urandom_range(0, 4))
					0:       return 16'h8000;
					1:       return 16'h7fff;
					2:       return 16'h0000;
					3:       return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			default: return DATA_W'($urandom_range(0, 1023)) - 16'd512;
		endcase
	endfunction

	task automatic send_random(int n);
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] br, bi;
		repeat (n) begin
			f  = ($urandom_range(0, 19) == 0) ? FUNC_W'($urandom_range(5, 7))
			                                  : FUNC_W'($urandom_range(0, 4));
			br = pick_val();
			bi = pick_val();
			// some divides by zero
			if (f == FN_DIV && $urandom_range(0, 15) == 0) begin
				br = '0;
				bi = '0;
			end
			send(f, pick_val(), pick_val(), br, bi);
		end
	endtask

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		wdog         = 0;
		src_idle_pct = 38;
		snk_idle_pct = 78;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each operation, zero divisor, unused codes
		send(FN_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send(FN_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
		send(FN_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send(FN_SUB, 16'h0000, 16'h0000, 16'h8000, 16'hffff);
		send(FN_NEG, 16'h8000, 16'h7fff, 16'h1234, 16'h5678);
		send(FN_NEG, 16'h0000, 16'h8000, 16'hffff, 16'hffff);
		send(FN_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send(FN_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send(FN_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
		send(FN_MUL, 16'h0180, 16'hff40, 16'h0200, 16'h0100);
		send(FN_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
		send(FN_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send(FN_DIV, 16'hff00, 16'h0100, 16'h0300, 16'h0000);
		send(FN_DIV, 16'h0100, 16'h0000, 16'h0000, 16'hfd00);
		send(FN_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send(FN_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send(FN_DIV, 16'h0000, 16'hffff, 16'h7fff, 16'h7fff);
		send(3'd5, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send(3'd6, 16'h8000, 16'h7fff, 16'h0000, 16'h0001);
		send(3'd7, 16'h1234, 16'hffff, 16'h0000, 16'h0000);
		wait_drained();

		send_random(470);
		src_idle_pct = 78;
		snk_idle_pct = 38;
		send_random(470);
		wait_drained();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_random(470);
		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);

		$display("checked %0d results: add %0d sub %0d neg %0d mul %0d div %0d unused %0d",
			sb.checked, sb.n_op[0], sb.n_op[1], sb.n_op[2], sb.n_op[3], sb.n_op[4],
			sb.n_op[5] + sb.n_op[6] + sb.n_op[7]);
		$display("saturated %0d, divide by zero %0d, under three idle patterns",
			sb.n_sat, sb.n_dz);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** complex_arith_unit: PASSED **");
		else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
			$display("** complex_arith_unit: FAILED **");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arith_unit.sv
bench/complex_arith_unit_tb.sv
